// File: hdl/iri_pkg.sv
// Shared types and constants for the image rotation inverse mapper.
package iri_pkg;

  localparam int FRAC_W  = 14;
  localparam int PROD_W  = 24;
  localparam int SUM_W   = 26;
  localparam int COORD_W = SUM_W - FRAC_W;
  localparam int LIM_W   = COORD_W - 1;
  localparam int CH_N    = 4;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [2:0] REG_WIDTH    = 3'd0;
  localparam logic [2:0] REG_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_CHANNELS = 3'd2;
  localparam logic [2:0] REG_CENTER_X = 3'd3;
  localparam logic [2:0] REG_CENTER_Y = 3'd4;
  localparam logic [2:0] REG_COS      = 3'd5;
  localparam logic [2:0] REG_SIN      = 3'd6;

  typedef struct packed {
    logic [7:0]         width;
    logic [7:0]         height;
    logic [2:0]         channels;
    logic [6:0]         center_x;
    logic [6:0]         center_y;
    logic signed [15:0] cos_term;
    logic signed [15:0] sin_term;
  } iri_cfg_t;

  typedef struct packed {
    logic                      action;
    logic                      keep;
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic [CH_N-1:0][7:0]      pix;
  } iri_item_t;

  typedef struct packed {
    logic                 in_frame;
    logic [CH_N-1:0][7:0] pix;
  } iri_res_t;

endpackage

// File: hdl/image_rotation_inverse_map.sv
// Nearest-neighbor image rotation by inverse mapping, top level.
// Load words write one 4-channel pixel into an internal frame store of
// MAX_WIDTH x MAX_HEIGHT words; query words return the source pixel that
// maps onto the named output pixel, with zeros and inside_res low when it
// falls outside the image. Both kinds of word are taken at one per clock
// while full is low, and are carried out in the order accepted. A query's
// result goes through the offsets captured at acceptance, then three more
// front stages (products, sums, truncation and bound check), the queue,
// the registered frame store read and the result queue to the result
// ports. The store is a single memory with one access per clock, which
// sets the rate of one word per cycle. The store is not cleared; every
// pixel must be loaded before it is queried. Configuration is written
// through cfg_valid and cfg_index/cfg_data, by the user only while no
// word is in flight, not enforced by the block; cfg_ready is always high.
module image_rotation_inverse_map import iri_pkg::*; #(
  parameter int MAX_WIDTH    = 128,
  parameter int MAX_HEIGHT   = 128,
  parameter int MAX_CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        action,
  input  logic [6:0]  x,
  input  logic [6:0]  y,
  input  logic [7:0]  in_ch0,
  input  logic [7:0]  in_ch1,
  input  logic [7:0]  in_ch2,
  input  logic [7:0]  in_ch3,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_ch0,
  output logic [7:0]  out_ch1,
  output logic [7:0]  out_ch2,
  output logic [7:0]  out_ch3,
  output logic        inside_res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int Q_DEPTH = 8;
  localparam int QCW     = $clog2(Q_DEPTH + 1);
  localparam int O_DEPTH = 4;
  localparam int OCW     = $clog2(O_DEPTH + 1);

  iri_cfg_t             cfg;
  logic [CH_N-1:0][7:0] in_pix;
  logic                 item_valid;
  iri_item_t            item;
  iri_item_t            q_item;
  logic                 q_pop;
  logic                 q_empty;
  logic [QCW-1:0]       q_count;
  logic                 o_push;
  iri_res_t             o_res;
  iri_res_t             res;
  logic [OCW-1:0]       o_count;
  logic                 out_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width    <= 8'd128;
      cfg.height   <= 8'd128;
      cfg.channels <= 3'd3;
      cfg.center_x <= 7'd64;
      cfg.center_y <= 7'd64;
      cfg.cos_term <= 16'sd16384;
      cfg.sin_term <= 16'sd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WIDTH:    cfg.width    <= cfg_data[7:0];
        REG_HEIGHT:   cfg.height   <= cfg_data[7:0];
        REG_CHANNELS: cfg.channels <= cfg_data[2:0];
        REG_CENTER_X: cfg.center_x <= cfg_data[6:0];
        REG_CENTER_Y: cfg.center_y <= cfg_data[6:0];
        REG_COS:      cfg.cos_term <= $signed(cfg_data);
        REG_SIN:      cfg.sin_term <= $signed(cfg_data);
        default:      cfg          <= cfg;
      endcase
    end
  end

  assign in_pix = {in_ch3, in_ch2, in_ch1, in_ch0};

  iri_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .Q_DEPTH    (Q_DEPTH),
    .QCW        (QCW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .push       (push),
    .full       (full),
    .action     (action),
    .x          (x),
    .y          (y),
    .in_pix     (in_pix),
    .q_count    (q_count),
    .item_valid (item_valid),
    .item       (item)
  );

  iri_fifo #(
    .WIDTH ($bits(iri_item_t)),
    .DEPTH (Q_DEPTH),
    .CW    (QCW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (item_valid),
    .push_data (item),
    .pop       (q_pop),
    .pop_data  (q_item),
    .empty     (q_empty),
    .count     (q_count)
  );

  iri_back #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_CHANNELS (MAX_CHANNELS),
    .O_DEPTH      (O_DEPTH),
    .OCW          (OCW)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .o_count (o_count),
    .o_push  (o_push),
    .o_res   (o_res)
  );

  assign out_pop = pop && !empty;

  iri_fifo #(
    .WIDTH ($bits(iri_res_t)),
    .DEPTH (O_DEPTH),
    .CW    (OCW)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (o_push),
    .push_data (o_res),
    .pop       (out_pop),
    .pop_data  (res),
    .empty     (empty),
    .count     (o_count)
  );

  assign out_ch0    = res.pix[0];
  assign out_ch1    = res.pix[1];
  assign out_ch2    = res.pix[2];
  assign out_ch3    = res.pix[3];
  assign inside_res = res.in_frame;

endmodule

// File: hdl/iri_fifo.sv
// Small register-based word queue with occupancy count.
module iri_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int CW    = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty,
  output logic [CW-1:0]    count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  assign pop_data = mem[rd_ptr];
  assign empty    = (count == '0);

endmodule

// File: hdl/iri_front.sv
// Front end: accepts words, computes the inverse-mapped source position, classifies.
module iri_front import iri_pkg::*; #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int Q_DEPTH    = 8,
  parameter int QCW        = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  iri_cfg_t             cfg,
  input  logic                 push,
  output logic                 full,
  input  logic                 action,
  input  logic [6:0]           x,
  input  logic [6:0]           y,
  input  logic [CH_N-1:0][7:0] in_pix,
  input  logic [QCW-1:0]       q_count,
  output logic                 item_valid,
  output iri_item_t            item
);

  localparam logic [LIM_W-1:0] MAXW_L = LIM_W'(MAX_WIDTH);
  localparam logic [LIM_W-1:0] MAXH_L = LIM_W'(MAX_HEIGHT);

  logic             accept;
  logic [LIM_W-1:0] w_eff;
  logic [LIM_W-1:0] h_eff;
  logic [2:0]       inflight;

  logic                 s1v, s2v, s3v, s4v;
  logic                 s1_act, s2_act, s3_act;
  logic [6:0]           s1_x, s2_x, s3_x;
  logic [6:0]           s1_y, s2_y, s3_y;
  logic [CH_N-1:0][7:0] s1_pix, s2_pix, s3_pix;
  logic                 s1_qin, s2_qin, s3_qin;
  logic                 s1_lin, s2_lin, s3_lin;
  logic signed [7:0]    s1_dx, s1_dy;
  logic signed [PROD_W-1:0] s2_pxc, s2_pys, s2_pxs, s2_pyc;
  logic signed [SUM_W-1:0]  s3_nx, s3_ny;

  logic signed [SUM_W-1:0]   nbx, nby;
  logic signed [COORD_W-1:0] sx, sy;
  logic                      in_frame;

  assign w_eff = (LIM_W'(cfg.width) > MAXW_L) ? MAXW_L : LIM_W'(cfg.width);
  assign h_eff = (LIM_W'(cfg.height) > MAXH_L) ? MAXH_L : LIM_W'(cfg.height);

  assign inflight = {2'b0, s1v} + {2'b0, s2v} + {2'b0, s3v} + {2'b0, s4v};
  assign full     = ({1'b0, q_count} + (QCW+1)'(inflight)) >= (QCW+1)'(Q_DEPTH);
  assign accept   = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1v <= 1'b0;
      s2v <= 1'b0;
      s3v <= 1'b0;
      s4v <= 1'b0;
    end else begin
      s1v <= accept;
      s2v <= s1v;
      s3v <= s2v;
      s4v <= s3v;
    end
  end

  // offsets from the center
  always_ff @(posedge clk) begin
    s1_act <= action;
    s1_x   <= x;
    s1_y   <= y;
    s1_pix <= in_pix;
    s1_dx  <= $signed({1'b0, x}) - $signed({1'b0, cfg.center_x});
    s1_dy  <= $signed({1'b0, y}) - $signed({1'b0, cfg.center_y});
    s1_qin <= (LIM_W'(x) < w_eff) && (LIM_W'(y) < h_eff);
    s1_lin <= (LIM_W'(x) < MAXW_L) && (LIM_W'(y) < MAXH_L);
  end

  // rotation products
  always_ff @(posedge clk) begin
    s2_act <= s1_act;
    s2_x   <= s1_x;
    s2_y   <= s1_y;
    s2_pix <= s1_pix;
    s2_qin <= s1_qin;
    s2_lin <= s1_lin;
    s2_pxc <= s1_dx * cfg.cos_term;
    s2_pys <= s1_dy * cfg.sin_term;
    s2_pxs <= s1_dx * cfg.sin_term;
    s2_pyc <= s1_dy * cfg.cos_term;
  end

  // sums with center added back
  always_ff @(posedge clk) begin
    s3_act <= s2_act;
    s3_x   <= s2_x;
    s3_y   <= s2_y;
    s3_pix <= s2_pix;
    s3_qin <= s2_qin;
    s3_lin <= s2_lin;
    s3_nx  <= SUM_W'(s2_pxc) - SUM_W'(s2_pys)
              + $signed({5'b0, cfg.center_x, {FRAC_W{1'b0}}});
    s3_ny  <= SUM_W'(s2_pxs) + SUM_W'(s2_pyc)
              + $signed({5'b0, cfg.center_y, {FRAC_W{1'b0}}});
  end

  // truncate toward zero, bound check
  always_comb begin
    nbx      = s3_nx + (s3_nx[SUM_W-1] ? SUM_W'((1 << FRAC_W) - 1) : '0);
    nby      = s3_ny + (s3_ny[SUM_W-1] ? SUM_W'((1 << FRAC_W) - 1) : '0);
    sx       = nbx[SUM_W-1:FRAC_W];
    sy       = nby[SUM_W-1:FRAC_W];
    in_frame = s3_qin
               && !sx[COORD_W-1] && (sx[LIM_W-1:0] < w_eff)
               && !sy[COORD_W-1] && (sy[LIM_W-1:0] < h_eff);
  end

  always_ff @(posedge clk) begin
    item.action <= s3_act;
    item.pix    <= s3_pix;
    if (s3_act == ACT_LOAD) begin
      item.keep <= s3_lin;
      item.sx   <= COORD_W'(s3_x);
      item.sy   <= COORD_W'(s3_y);
    end else begin
      item.keep <= in_frame;
      item.sx   <= sx;
      item.sy   <= sy;
    end
  end

  assign item_valid = s4v;

endmodule

// File: hdl/iri_back.sv
// Back end: frame store writes for loads, reads and channel masking for queries.
module iri_back import iri_pkg::*; #(
  parameter int MAX_WIDTH    = 128,
  parameter int MAX_HEIGHT   = 128,
  parameter int MAX_CHANNELS = 4,
  parameter int O_DEPTH      = 4,
  parameter int OCW          = 3
) (
  input  logic           clk,
  input  logic           rst,
  input  iri_cfg_t       cfg,
  input  logic           q_empty,
  input  iri_item_t      q_item,
  output logic           q_pop,
  input  logic [OCW-1:0] o_count,
  output logic           o_push,
  output iri_res_t       o_res
);

  localparam int         DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int         AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [2:0] MAXC_L = 3'(MAX_CHANNELS);

  logic [CH_N-1:0][7:0] store [DEPTH];
  logic [AW-1:0]        addr;
  logic [LIM_W-1:0]     xu;
  logic [LIM_W-1:0]     yu;
  logic [CH_N-1:0][7:0] rd_data;
  logic                 r_valid;
  logic                 r_inside;
  logic [2:0]           nch;

  assign q_pop = !q_empty
                 && (({1'b0, o_count} + (OCW+1)'(r_valid)) < (OCW+1)'(O_DEPTH));

  assign xu   = q_item.sx[LIM_W-1:0];
  assign yu   = q_item.sy[LIM_W-1:0];
  assign addr = AW'(yu * MAX_WIDTH + xu);

  always_ff @(posedge clk) begin
    if (q_pop && q_item.action == ACT_LOAD && q_item.keep) begin
      store[addr] <= q_item.pix;
    end
    if (q_pop && q_item.action == ACT_QUERY) begin
      rd_data <= store[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else begin
      r_valid <= q_pop && (q_item.action == ACT_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      r_inside <= q_item.keep;
    end
  end

  assign nch = (cfg.channels > MAXC_L) ? MAXC_L : cfg.channels;

  always_comb begin
    o_res.in_frame = r_inside;
    for (int c = 0; c < CH_N; c++) begin
      o_res.pix[c] = (r_inside && (3'(c) < nch)) ? rd_data[c] : 8'd0;
    end
  end

  assign o_push = r_valid;

endmodule

// File: dv/rotated_pixel_checker.sv
`timescale 1ns / 100ps
// Checker for the image rotation mapper: mirrors config and frame store, predicts and compares.
module rotated_pixel_checker import iri_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic        action,
  input  logic [6:0]  x,
  input  logic [6:0]  y,
  input  logic [7:0]  in_ch0,
  input  logic [7:0]  in_ch1,
  input  logic [7:0]  in_ch2,
  input  logic [7:0]  in_ch3,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  out_ch0,
  input  logic [7:0]  out_ch1,
  input  logic [7:0]  out_ch2,
  input  logic [7:0]  out_ch3,
  input  logic        inside_res,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int unsigned results_due,
  output int unsigned mismatches
);

  localparam longint UNIT_Q14 = 16384;
  localparam longint ROW_LEN  = 128;
  localparam longint COL_LEN  = 128;

  logic [7:0]         img_w;
  logic [7:0]         img_h;
  logic [2:0]         img_ch;
  logic [6:0]         pivot_x;
  logic [6:0]         pivot_y;
  logic signed [15:0] cos_q;
  logic signed [15:0] sin_q;
  logic [31:0]        frame_copy [0:16383];
  iri_res_t           pixels_due [$];

  function automatic iri_res_t rotated_pixel(input logic [6:0] qx, input logic [6:0] qy);
    longint   w, h, nch, dx, dy, nx, ny, sx, sy;
    logic [31:0] word;
    iri_res_t res;
    int       c;
    w = longint'(img_w);
    if (w > ROW_LEN) w = ROW_LEN;
    h = longint'(img_h);
    if (h > COL_LEN) h = COL_LEN;
    nch = longint'(img_ch);
    if (nch > 4) nch = 4;
    res = '0;
    if (qx < w && qy < h) begin
      dx = longint'(qx) - longint'(pivot_x);
      dy = longint'(qy) - longint'(pivot_y);
      nx = dx * longint'(cos_q) - dy * longint'(sin_q) + longint'(pivot_x) * UNIT_Q14;
      ny = dx * longint'(sin_q) + dy * longint'(cos_q) + longint'(pivot_y) * UNIT_Q14;
      sx = nx / UNIT_Q14;
      sy = ny / UNIT_Q14;
      if (sx >= 0 && sx < w && sy >= 0 && sy < h) begin
        res.in_frame = 1'b1;
        word = frame_copy[sy * ROW_LEN + sx];
        for (c = 0; c < 4; c++) begin
          if (c < nch) res.pix[c] = word[8*c +: 8];
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    iri_res_t want;
    if (rst) begin
      img_w   = 8'd128;
      img_h   = 8'd128;
      img_ch  = 3'd3;
      pivot_x = 7'd64;
      pivot_y = 7'd64;
      cos_q   = 16'sd16384;
      sin_q   = 16'sd0;
      pixels_due.delete();
      results_due <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WIDTH:    img_w   = cfg_data[7:0];
          REG_HEIGHT:   img_h   = cfg_data[7:0];
          REG_CHANNELS: img_ch  = cfg_data[2:0];
          REG_CENTER_X: pivot_x = cfg_data[6:0];
          REG_CENTER_Y: pivot_y = cfg_data[6:0];
          REG_COS:      cos_q   = cfg_data;
          REG_SIN:      sin_q   = cfg_data;
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (pixels_due.size() == 0) begin
          report_mismatch("result word with nothing expected",
                          {out_ch3, out_ch2, out_ch1, out_ch0}, '0);
        end else begin
          want = pixels_due.pop_front();
          if (out_ch0 !== want.pix[0]) report_mismatch("out_ch0", out_ch0, want.pix[0]);
          if (out_ch1 !== want.pix[1]) report_mismatch("out_ch1", out_ch1, want.pix[1]);
          if (out_ch2 !== want.pix[2]) report_mismatch("out_ch2", out_ch2, want.pix[2]);
          if (out_ch3 !== want.pix[3]) report_mismatch("out_ch3", out_ch3, want.pix[3]);
          if (inside_res !== want.in_frame)
            report_mismatch("inside_res", inside_res, want.in_frame);
        end
      end
      if (push && !full) begin
        if (action == ACT_LOAD) frame_copy[{y, x}] = {in_ch3, in_ch2, in_ch1, in_ch0};
        else pixels_due.push_back(rotated_pixel(x, y));
      end
      results_due <= pixels_due.size();
    end
  end

endmodule

// File: dv/tb_image_rotation_inverse_map.sv
`timescale 1ns / 100ps
// Testbench top for the image rotation mapper: drives words and config, gives the verdict.
module tb_image_rotation_inverse_map;
  import iri_pkg::*;

  localparam int  SETTLE      = 16;
  localparam int  TOTAL_WORDS = 1300;
  localparam int  HOLD_CYCLES = 400;
  localparam real PI          = 3.14159265358979;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic        action;
  logic [6:0]  x;
  logic [6:0]  y;
  logic [7:0]  in_ch0;
  logic [7:0]  in_ch1;
  logic [7:0]  in_ch2;
  logic [7:0]  in_ch3;
  logic        empty;
  logic        pop;
  logic [7:0]  out_ch0;
  logic [7:0]  out_ch1;
  logic [7:0]  out_ch2;
  logic [7:0]  out_ch3;
  logic        inside_res;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  int unsigned results_due;
  int unsigned mismatches;
  int unsigned words_sent;
  int unsigned pops_taken;
  int unsigned eff_w;
  int unsigned eff_h;
  bit          tx_burst;
  bit          rx_burst;
  bit          loaded [0:127][0:127];

  image_rotation_inverse_map DUT (.*);

  rotated_pixel_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [15:0] pick_extreme();
    case ($urandom_range(0, 4))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h4000;
      3:       return 16'hC000;
      default: return 16'h0000;
    endcase
  endfunction

  task automatic send_word(input logic act, input logic [6:0] px, input logic [6:0] py,
                           input logic [31:0] data);
    int unsigned gap;
    gap = tx_burst ? 0 : pick_gap();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push   <= 1'b1;
    action <= act;
    x      <= px;
    y      <= py;
    in_ch0 <= data[7:0];
    in_ch1 <= data[15:8];
    in_ch2 <= data[23:16];
    in_ch3 <= data[31:24];
    do @(posedge clk); while (full);
    words_sent++;
    if (act == ACT_LOAD) loaded[py][px] = 1'b1;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apply_config(input logic [7:0] w, input logic [7:0] h, input logic [2:0] ch,
                              input logic [6:0] cx, input logic [6:0] cy,
                              input logic [15:0] cs, input logic [15:0] sn);
    int unsigned r, c;
    drain();
    write_reg(REG_WIDTH,    {8'($urandom()), w});
    write_reg(REG_HEIGHT,   {8'($urandom()), h});
    write_reg(REG_CHANNELS, {13'($urandom()), ch});
    write_reg(REG_CENTER_X, {9'($urandom()), cx});
    write_reg(REG_CENTER_Y, {9'($urandom()), cy});
    write_reg(REG_COS,      cs);
    write_reg(REG_SIN,      sn);
    cfg_valid <= 1'b0;
    eff_w = (w > 128) ? 128 : w;
    eff_h = (h > 128) ? 128 : h;
    // fill every pixel a query can land on
    for (r = 0; r < eff_h; r++) begin
      for (c = 0; c < eff_w; c++) begin
        if (!loaded[r][c]) send_word(ACT_LOAD, 7'(c), 7'(r), $urandom());
        if ($urandom_range(0, 9) == 0)
          send_word(ACT_LOAD, 7'($urandom()), 7'($urandom()), $urandom());
      end
    end
  endtask

  initial begin : rx_side
    int unsigned hold;
    pop <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      hold = rx_burst ? 0 : pick_gap();
      if (pops_taken == 150 || pops_taken == 700) hold = HOLD_CYCLES;
      if (hold != 0) begin
        pop <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      pops_taken++;
      if (pops_taken % 97 == 0) rx_burst = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin : tx_side
    logic [7:0]  w;
    logic [7:0]  h;
    logic [6:0]  cx;
    logic [6:0]  cy;
    logic [15:0] cs;
    logic [15:0] sn;
    logic [6:0]  qx;
    logic [6:0]  qy;
    int unsigned n_query;
    real         ang;
    rst       <= 1'b1;
    push      <= 1'b0;
    action    <= ACT_LOAD;
    x         <= '0;
    y         <= '0;
    in_ch0    <= '0;
    in_ch1    <= '0;
    in_ch2    <= '0;
    in_ch3    <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_WIDTH;
    cfg_data  <= '0;
    tx_burst  = 1'b0;
    rx_burst  = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset settings map each pixel onto itself
    send_word(ACT_LOAD, 7'd0, 7'd0, 32'hFFFFFFFF);
    send_word(ACT_LOAD, 7'd127, 7'd127, 32'h00000000);
    send_word(ACT_LOAD, 7'd127, 7'd0, 32'h80FF01A5);
    send_word(ACT_LOAD, 7'd0, 7'd127, 32'h5A7F00FF);
    send_word(ACT_QUERY, 7'd0, 7'd0, $urandom());
    send_word(ACT_QUERY, 7'd127, 7'd127, $urandom());
    send_word(ACT_QUERY, 7'd127, 7'd0, $urandom());
    send_word(ACT_QUERY, 7'd0, 7'd127, $urandom());

    // half-pixel negative offsets truncate toward zero
    apply_config(8'd2, 8'd2, 3'd4, 7'd0, 7'd0, 16'hE000, 16'h0000);
    send_word(ACT_QUERY, 7'd1, 7'd0, $urandom());
    send_word(ACT_QUERY, 7'd1, 7'd1, $urandom());
    send_word(ACT_QUERY, 7'd0, 7'd1, $urandom());
    send_word(ACT_QUERY, 7'd2, 7'd0, $urandom());
    send_word(ACT_QUERY, 7'd0, 7'd2, $urandom());
    send_word(ACT_QUERY, 7'd127, 7'd127, $urandom());

    while (words_sent < TOTAL_WORDS) begin
      case ($urandom_range(0, 9))
        0: begin
          w = 8'($urandom_range(128, 255));
          h = 8'($urandom_range(0, 2));
        end
        1: begin
          w = 8'($urandom_range(0, 2));
          h = 8'($urandom_range(128, 255));
        end
        2: begin
          if ($urandom_range(0, 1) == 0) begin
            w = 8'd0;
            h = 8'($urandom());
          end else begin
            w = 8'($urandom());
            h = 8'd0;
          end
        end
        default: begin
          w = 8'($urandom_range(1, 12));
          h = 8'($urandom_range(1, 12));
        end
      endcase
      cx = ($urandom_range(0, 3) == 0) ? 7'($urandom())
                                       : 7'($urandom_range(0, (w > 127) ? 127 : w));
      cy = ($urandom_range(0, 3) == 0) ? 7'($urandom())
                                       : 7'($urandom_range(0, (h > 127) ? 127 : h));
      case ($urandom_range(0, 7))
        0: begin
          cs = 16'($urandom());
          sn = 16'($urandom());
        end
        1: begin
          cs = pick_extreme();
          sn = pick_extreme();
        end
        default: begin
          ang = $urandom_range(0, 359) * PI / 180.0;
          cs  = 16'($rtoi($cos(ang) * 16384.0));
          sn  = 16'($rtoi($sin(ang) * 16384.0));
        end
      endcase
      apply_config(w, h, 3'($urandom()), cx, cy, cs, sn);
      tx_burst = ($urandom_range(0, 3) == 0);
      n_query  = $urandom_range(20, 80);
      repeat (n_query) begin
        if ($urandom_range(0, 6) == 0) begin
          if (eff_w != 0 && eff_h != 0 && $urandom_range(0, 1) == 0)
            send_word(ACT_LOAD, 7'($urandom_range(0, eff_w - 1)),
                      7'($urandom_range(0, eff_h - 1)), $urandom());
          else
            send_word(ACT_LOAD, 7'($urandom()), 7'($urandom()), $urandom());
        end
        if ($urandom_range(0, 4) == 0) begin
          qx = 7'($urandom());
          qy = 7'($urandom());
        end else begin
          qx = 7'($urandom_range(0, (eff_w + 1 > 127) ? 127 : eff_w + 1));
          qy = 7'($urandom_range(0, (eff_h + 1 > 127) ? 127 : eff_h + 1));
        end
        send_word(ACT_QUERY, qx, qy, $urandom());
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: image_rotation_inverse_map.f
hdl/iri_pkg.sv
hdl/iri_fifo.sv
hdl/iri_front.sv
hdl/iri_back.sv
hdl/image_rotation_inverse_map.sv
dv/rotated_pixel_checker.sv
dv/tb_image_rotation_inverse_map.sv
